@@ rtl/assert_macros.svh @@
// shared assertion macros, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define PNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true out of reset
`define PNM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/pnm_pkg.sv @@
package pnm_pkg;

  parameter int unsigned DIM_BITS_DEF = 16;

  // ascii codes used by the header syntax
  parameter logic [7:0] CH_P    = 8'h50;
  parameter logic [7:0] CH_5    = 8'h35;
  parameter logic [7:0] CH_6    = 8'h36;
  parameter logic [7:0] CH_HASH = 8'h23;
  parameter logic [7:0] CH_LF   = 8'h0A;
  parameter logic [7:0] CH_CR   = 8'h0D;
  parameter logic [7:0] CH_ZERO = 8'h30;
  parameter logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_PIXEL  = 2'd1,
    EV_ERROR  = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_SAMPLE   = 3'd2,
    ERR_SHORT    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } error_code_e;

  typedef struct packed {
    event_kind_e kind;
    error_code_e err;
    logic        rgb;
    logic        eoi;
  } pnm_ctrl_t;

endpackage

@@ rtl/pnm_num_acc.sv @@
module pnm_num_acc #(
  parameter int unsigned DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic [7:0]          data_i,
  input  logic [DIM_BITS-1:0] acc_i,
  output logic                digit_o,
  output logic [DIM_BITS-1:0] acc_next_o,
  output logic                ovf_o
);

  localparam int unsigned ExtW = DIM_BITS + 4;

  logic [3:0]      digit_val;
  logic [ExtW-1:0] acc_ext;
  logic [ExtW-1:0] sum;

  assign digit_o   = (data_i >= pnm_pkg::CH_ZERO) && (data_i <= pnm_pkg::CH_NINE);
  // ascii digits sit at 0x30 to 0x39, so the low nibble is the value
  assign digit_val = data_i[3:0];
  assign acc_ext   = ExtW'(acc_i);

  // acc * 10 as two shifts plus the new digit
  assign sum        = (acc_ext << 3) + (acc_ext << 1) + ExtW'(digit_val);
  assign acc_next_o = sum[DIM_BITS-1:0];
  assign ovf_o      = |sum[ExtW-1:DIM_BITS];

endmodule

@@ rtl/pnm_parse_core.sv @@
`include "assert_macros.svh"

module pnm_parse_core #(
  parameter int unsigned DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output logic                res_valid_o,
  output pnm_pkg::pnm_ctrl_t  res_ctrl_o,
  output logic [DIM_BITS-1:0] res_width_o,
  output logic [DIM_BITS-1:0] res_height_o,
  output logic [DIM_BITS-1:0] res_maxval_o,
  output logic [DIM_BITS-1:0] res_col_o,
  output logic [DIM_BITS-1:0] res_row_o,
  output logic [7:0]          res_red_o,
  output logic [7:0]          res_green_o,
  output logic [7:0]          res_blue_o
);

  typedef enum logic [2:0] {
    PH_MAGIC_P = 3'd0,
    PH_MAGIC_D = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_HEIGHT  = 3'd3,
    PH_MAXVAL  = 3'd4,
    PH_PIXELS  = 3'd5,
    PH_SKIP    = 3'd6
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                rgb_q, rgb_d;
  logic [DIM_BITS-1:0] acc_q, acc_d;
  logic                digit_seen_q, digit_seen_d;
  logic                comment_q, comment_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS-1:0] maxval_q, maxval_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [1:0]          comp_q, comp_d;
  logic [7:0]          red_q, red_d;
  logic [7:0]          green_q, green_d;

  logic                is_digit;
  logic [DIM_BITS-1:0] acc_next;
  logic                acc_ovf;
  logic                is_nl;
  logic                take;
  logic [7:0]          sa, sg, sb;
  logic                over;
  logic                col_last, row_last;
  logic                in_number;

  pnm_num_acc #(
    .DIM_BITS(DIM_BITS)
  ) u_num_acc (
    .data_i    (data_byte_i),
    .acc_i     (acc_q),
    .digit_o   (is_digit),
    .acc_next_o(acc_next),
    .ovf_o     (acc_ovf)
  );

  assign is_nl = (data_byte_i == pnm_pkg::CH_LF) || (data_byte_i == pnm_pkg::CH_CR);

  assign in_number = (phase_q == PH_WIDTH) || (phase_q == PH_HEIGHT) || (phase_q == PH_MAXVAL);

  assign col_last = ((DIM_BITS + 1)'(col_q) + (DIM_BITS + 1)'(1)) >= (DIM_BITS + 1)'(width_q);
  assign row_last = ((DIM_BITS + 1)'(row_q) + (DIM_BITS + 1)'(1)) >= (DIM_BITS + 1)'(height_q);

  always_comb begin
    phase_d      = phase_q;
    rgb_d        = rgb_q;
    acc_d        = acc_q;
    digit_seen_d = digit_seen_q;
    comment_d    = comment_q;
    width_d      = width_q;
    height_d     = height_q;
    maxval_d     = maxval_q;
    col_d        = col_q;
    row_d        = row_q;
    comp_d       = comp_q;
    red_d        = red_q;
    green_d      = green_q;

    res_valid_o     = 1'b0;
    res_ctrl_o.kind = pnm_pkg::EV_HEADER;
    res_ctrl_o.err  = pnm_pkg::ERR_NONE;
    res_ctrl_o.rgb  = 1'b0;
    res_ctrl_o.eoi  = 1'b0;
    res_red_o       = '0;
    res_green_o     = '0;
    res_blue_o      = '0;
    res_col_o       = '0;
    res_row_o       = '0;
    res_width_o     = '0;
    res_height_o    = '0;
    res_maxval_o    = '0;

    take = 1'b0;
    sa   = '0;
    sg   = '0;
    sb   = '0;
    over = 1'b0;

    case (phase_q)
      PH_MAGIC_P: begin
        if (data_byte_i == pnm_pkg::CH_P) begin
          phase_d = PH_MAGIC_D;
        end else begin
          res_valid_o     = 1'b1;
          res_ctrl_o.kind = pnm_pkg::EV_ERROR;
          res_ctrl_o.err  = pnm_pkg::ERR_MAGIC;
          phase_d         = PH_SKIP;
        end
      end
      PH_MAGIC_D: begin
        if (data_byte_i == pnm_pkg::CH_5 || data_byte_i == pnm_pkg::CH_6) begin
          rgb_d   = (data_byte_i == pnm_pkg::CH_6);
          phase_d = PH_WIDTH;
        end else begin
          res_valid_o     = 1'b1;
          res_ctrl_o.kind = pnm_pkg::EV_ERROR;
          res_ctrl_o.err  = pnm_pkg::ERR_MAGIC;
          phase_d         = PH_SKIP;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        // inside a comment only cr or lf matters, and it then separates
        if (!comment_q || is_nl) begin
          comment_d = 1'b0;
          if (data_byte_i == pnm_pkg::CH_HASH) begin
            comment_d = 1'b1;
          end else if (is_digit) begin
            if (acc_ovf) begin
              res_valid_o     = 1'b1;
              res_ctrl_o.kind = pnm_pkg::EV_ERROR;
              res_ctrl_o.err  = pnm_pkg::ERR_OVERFLOW;
              phase_d         = PH_SKIP;
            end else begin
              acc_d        = acc_next;
              digit_seen_d = 1'b1;
            end
          end else if (digit_seen_q) begin
            case (phase_q)
              PH_WIDTH: begin
                width_d = acc_q;
                phase_d = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                height_d = acc_q;
                phase_d  = PH_MAXVAL;
              end
              default: begin
                maxval_d        = acc_q;
                res_valid_o     = 1'b1;
                res_ctrl_o.kind = pnm_pkg::EV_HEADER;
                if (width_q == '0 || height_q == '0) begin
                  res_ctrl_o.eoi = 1'b1;
                  phase_d        = PH_SKIP;
                end else begin
                  phase_d = PH_PIXELS;
                end
              end
            endcase
            acc_d        = '0;
            digit_seen_d = 1'b0;
          end
        end
      end
      PH_PIXELS: begin
        if (!rgb_q) begin
          take = 1'b1;
          sa   = data_byte_i;
        end else begin
          case (comp_q)
            2'd0: begin
              red_d  = data_byte_i;
              comp_d = 2'd1;
            end
            2'd1: begin
              green_d = data_byte_i;
              comp_d  = 2'd2;
            end
            default: begin
              comp_d = 2'd0;
              take   = 1'b1;
              sa     = red_q;
              sg     = green_q;
              sb     = data_byte_i;
            end
          endcase
        end
        over = (DIM_BITS'(sa) > maxval_q) || (DIM_BITS'(sg) > maxval_q) ||
               (DIM_BITS'(sb) > maxval_q);
        if (take) begin
          res_valid_o = 1'b1;
          if (over) begin
            res_ctrl_o.kind = pnm_pkg::EV_ERROR;
            res_ctrl_o.err  = pnm_pkg::ERR_SAMPLE;
            phase_d         = PH_SKIP;
          end else begin
            res_ctrl_o.kind = pnm_pkg::EV_PIXEL;
            res_ctrl_o.eoi  = col_last && row_last;
            res_red_o       = sa;
            res_green_o     = sg;
            res_blue_o      = sb;
            res_col_o       = col_q;
            res_row_o       = row_q;
            if (col_last && row_last) begin
              phase_d = PH_SKIP;
            end else if (col_last) begin
              col_d = '0;
              row_d = row_q + DIM_BITS'(1);
            end else begin
              col_d = col_q + DIM_BITS'(1);
            end
          end
        end
      end
      default: ;
    endcase

    // early end of file replaces anything but an error, unless this beat leaves the parser in skip
    if (final_byte_i && !(res_valid_o && res_ctrl_o.kind == pnm_pkg::EV_ERROR) &&
        phase_d != PH_SKIP) begin
      res_valid_o     = 1'b1;
      res_ctrl_o.kind = pnm_pkg::EV_ERROR;
      res_ctrl_o.err  = pnm_pkg::ERR_SHORT;
      res_ctrl_o.eoi  = 1'b0;
      res_red_o       = '0;
      res_green_o     = '0;
      res_blue_o      = '0;
      res_col_o       = '0;
      res_row_o       = '0;
    end

    // header fields reflect the state after this beat
    res_ctrl_o.rgb = rgb_d;
    res_width_o    = width_d;
    res_height_o   = height_d;
    res_maxval_o   = maxval_d;

    if (final_byte_i) begin
      phase_d      = PH_MAGIC_P;
      rgb_d        = 1'b0;
      acc_d        = '0;
      digit_seen_d = 1'b0;
      comment_d    = 1'b0;
      width_d      = '0;
      height_d     = '0;
      maxval_d     = '0;
      col_d        = '0;
      row_d        = '0;
      comp_d       = '0;
      red_d        = '0;
      green_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MAGIC_P;
      rgb_q        <= 1'b0;
      acc_q        <= '0;
      digit_seen_q <= 1'b0;
      comment_q    <= 1'b0;
      width_q      <= '0;
      height_q     <= '0;
      maxval_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      comp_q       <= '0;
      red_q        <= '0;
      green_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      rgb_q        <= rgb_d;
      acc_q        <= acc_d;
      digit_seen_q <= digit_seen_d;
      comment_q    <= comment_d;
      width_q      <= width_d;
      height_q     <= height_d;
      maxval_q     <= maxval_d;
      col_q        <= col_d;
      row_q        <= row_d;
      comp_q       <= comp_d;
      red_q        <= red_d;
      green_q      <= green_d;
    end
  end

  `PNM_ASSERT(a_skip_silent, (step_i && phase_q == PH_SKIP) |-> !res_valid_o, "result in skip")
  `PNM_ASSERT(a_final_resets, (step_i && final_byte_i) |=> phase_q == PH_MAGIC_P, "no reset")
  `PNM_ASSERT(a_comment_phase, comment_q |-> in_number, "comment outside header numbers")

endmodule

@@ rtl/pnm_out_skid.sv @@
`include "assert_macros.svh"

module pnm_out_skid #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_data_o
);

  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             skid_valid_q;
  logic [DataW-1:0] skid_data_q;

  // a new beat can always land somewhere while the skid slot is empty
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  `PNM_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `PNM_ASSERT(a_stall_to_skid, (push_i && out_valid_q && !out_ready_i) |=> skid_valid_q, "stalled beat lost")
  `PNM_ASSERT_NEVER(a_no_overrun, push_i && skid_valid_q, "push into full buffer")

endmodule

@@ rtl/pnm_binary_stream_parser_unit.sv @@
// channel | direction | handshake                  | payload
// in      | sink      | in_valid_i / in_ready_o    | data_byte_i, final_byte_i
// out     | source    | out_valid_o / out_ready_i  | event and header fields, pixel fields
//
// one byte per cycle while in_ready_o is high; every byte is parsed in the cycle it is accepted and
// its result, if any, is written to the output register, or to the skid slot while the output stalls
// a two-entry output buffer (output register plus skid slot) holds results;
// in_ready_o drops only while both entries are full
// rst_ni clears all parse state and the buffer; no clearing pass is needed
// the beat marked final_byte_i returns the parser to its reset state
module pnm_binary_stream_parser_unit #(
  parameter int unsigned DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          event_kind_o,
  output logic [2:0]          error_code_o,
  output logic                color_mode_o,
  output logic [DIM_BITS-1:0] image_width_o,
  output logic [DIM_BITS-1:0] image_height_o,
  output logic [DIM_BITS-1:0] max_value_o,
  output logic [7:0]          gray_or_red_o,
  output logic [7:0]          green_sample_o,
  output logic [7:0]          blue_sample_o,
  output logic [DIM_BITS-1:0] pixel_column_o,
  output logic [DIM_BITS-1:0] pixel_row_o,
  output logic                end_of_image_o
);

  localparam int unsigned CtrlW = $bits(pnm_pkg::pnm_ctrl_t);
  localparam int unsigned ResW  = CtrlW + 5 * DIM_BITS + 24;

  logic                step;
  logic                res_valid;
  pnm_pkg::pnm_ctrl_t  res_ctrl;
  logic [DIM_BITS-1:0] res_width, res_height, res_maxval, res_col, res_row;
  logic [7:0]          res_red, res_green, res_blue;
  logic [ResW-1:0]     res_flat;
  logic [ResW-1:0]     out_flat;
  pnm_pkg::pnm_ctrl_t  out_ctrl;

  assign step = in_valid_i && in_ready_o;

  pnm_parse_core #(
    .DIM_BITS(DIM_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .res_valid_o (res_valid),
    .res_ctrl_o  (res_ctrl),
    .res_width_o (res_width),
    .res_height_o(res_height),
    .res_maxval_o(res_maxval),
    .res_col_o   (res_col),
    .res_row_o   (res_row),
    .res_red_o   (res_red),
    .res_green_o (res_green),
    .res_blue_o  (res_blue)
  );

  assign res_flat = {res_ctrl, res_width, res_height, res_maxval, res_col, res_row,
                     res_red, res_green, res_blue};

  pnm_out_skid #(
    .DataW(ResW)
  ) u_out_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step && res_valid),
    .push_data_i(res_flat),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_flat)
  );

  assign {out_ctrl, image_width_o, image_height_o, max_value_o, pixel_column_o, pixel_row_o,
          gray_or_red_o, green_sample_o, blue_sample_o} = out_flat;

  assign event_kind_o   = out_ctrl.kind;
  assign error_code_o   = out_ctrl.err;
  assign color_mode_o   = out_ctrl.rgb;
  assign end_of_image_o = out_ctrl.eoi;

endmodule
